/* rtl/core/mts_pkg.sv */
// Shared types and codes for the max-tracking stack.
`default_nettype none
package mts_pkg;

	// Operation codes on the func field.
	localparam logic [1:0] FUNC_PUSH    = 2'd0;
	localparam logic [1:0] FUNC_POP     = 2'd1;
	localparam logic [1:0] FUNC_INSPECT = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

	// What a cell loads on the next clock edge.
	typedef enum logic [1:0] {
		OP_HOLD      = 2'd0,
		OP_TAKE_PREV = 2'd1,
		OP_TAKE_NEXT = 2'd2
	} cell_op_t;

endpackage
`default_nettype wire

/* rtl/core/max_tracking_stack.sv */
// Top level of the max-tracking stack: control, counts and result register.
//
// A LIFO stack of signed values that also reports its running maximum.
// Requests enter on the in channel (func, push_value) and each request
// gives exactly one result on the out channel (removed_value, top_value,
// max_value, is_empty, depth_used, status). Both channels use valid/stall.
// The result is registered and shows on the out channel the cycle after
// acceptance, and a new request can be taken every cycle unless the
// receiver stalls. The elements and the (maximum, repeat count) pairs
// each live in a row of cells that shifts one place per push or pop, so
// only the top two cells of each row are ever looked at.
// When the receiver stalls, the result register holds and in_stall rises,
// so no request is taken until the held result is gone.
// Reset clears the element and pair counts and the result valid flag; the
// cell contents are not cleared and are never read before being written.
// A pop on an empty stack and a push on a full stack leave the state alone
// and report it in status.
`default_nettype none
module max_tracking_stack import mts_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int VALUE_BITS  = 32,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic        [1:0]            func,
	input  wire logic signed [VALUE_BITS-1:0] push_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed      [VALUE_BITS-1:0] removed_value,
	output logic signed      [VALUE_BITS-1:0] top_value,
	output logic signed      [VALUE_BITS-1:0] max_value,
	output logic                              is_empty,
	output logic             [CW-1:0]         depth_used,
	output logic             [1:0]            status
);

	localparam int PW = VALUE_BITS + CW;
	localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

	logic                  accept;
	logic [CW-1:0]         elem_cnt_q, elem_cnt_d;
	logic [CW-1:0]         pair_cnt_q, pair_cnt_d;

	cell_op_t              e_op, m_head_op, m_body_op;
	logic [VALUE_BITS-1:0] e_head, e_second;
	logic [PW-1:0]         m_head, m_second, m_head_in;
	logic [VALUE_BITS-1:0] m_val0, m_val1;
	logic [CW-1:0]         m_cnt0;

	logic [VALUE_BITS-1:0] popped_d, top_d, max_d;
	logic [1:0]            status_d;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] popped_q, top_q, max_q;
	logic                  empty_q;
	logic [CW-1:0]         depth_q;
	logic [1:0]            status_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign m_val0 = m_head[PW-1 -: VALUE_BITS];
	assign m_cnt0 = m_head[CW-1:0];
	assign m_val1 = m_second[PW-1 -: VALUE_BITS];

	always_comb begin
		e_op       = OP_HOLD;
		m_head_op  = OP_HOLD;
		m_body_op  = OP_HOLD;
		m_head_in  = {push_value, CW'(1)};
		elem_cnt_d = elem_cnt_q;
		pair_cnt_d = pair_cnt_q;
		popped_d   = '0;
		status_d   = STATUS_OK;
		top_d      = e_head;
		max_d      = m_val0;

		unique case (func)
			FUNC_PUSH: begin
				if (elem_cnt_q == FULL_COUNT) begin
					status_d = STATUS_PUSH_FULL;
				end else begin
					e_op       = OP_TAKE_PREV;
					elem_cnt_d = elem_cnt_q + CW'(1);
					top_d      = push_value;
					// A new maximum opens a pair; a tie only bumps its count.
					if (pair_cnt_q == '0 || push_value > $signed(m_val0)) begin
						m_head_op  = OP_TAKE_PREV;
						m_body_op  = OP_TAKE_PREV;
						pair_cnt_d = pair_cnt_q + CW'(1);
						max_d      = push_value;
					end else if (push_value == m_val0) begin
						m_head_op = OP_TAKE_PREV;
						m_head_in = {m_val0, m_cnt0 + CW'(1)};
					end
				end
			end
			FUNC_POP: begin
				if (elem_cnt_q == '0) begin
					status_d = STATUS_POP_EMPTY;
				end else begin
					popped_d   = e_head;
					e_op       = OP_TAKE_NEXT;
					elem_cnt_d = elem_cnt_q - CW'(1);
					top_d      = e_second;
					if (pair_cnt_q != '0 && e_head == m_val0) begin
						if (m_cnt0 <= CW'(1)) begin
							m_head_op  = OP_TAKE_NEXT;
							m_body_op  = OP_TAKE_NEXT;
							pair_cnt_d = pair_cnt_q - CW'(1);
							max_d      = m_val1;
						end else begin
							m_head_op = OP_TAKE_PREV;
							m_head_in = {m_val0, m_cnt0 - CW'(1)};
						end
					end
				end
			end
			FUNC_INSPECT: begin
				status_d = STATUS_OK;
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase

		if (elem_cnt_d == '0) begin
			top_d = '0;
			max_d = '0;
		end

		if (!accept) begin
			e_op      = OP_HOLD;
			m_head_op = OP_HOLD;
			m_body_op = OP_HOLD;
		end
	end

	mts_chain #(.WIDTH(VALUE_BITS), .DEPTH(STACK_DEPTH)) u_elem_chain (
		.clk     (clk),
		.op_head (e_op),
		.op_body (e_op),
		.head_in (push_value),
		.head    (e_head),
		.second  (e_second)
	);

	mts_chain #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_max_chain (
		.clk     (clk),
		.op_head (m_head_op),
		.op_body (m_body_op),
		.head_in (m_head_in),
		.head    (m_head),
		.second  (m_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q  <= '0;
			pair_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				elem_cnt_q  <= elem_cnt_d;
				pair_cnt_q  <= pair_cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			top_q    <= top_d;
			max_q    <= max_d;
			empty_q  <= (elem_cnt_d == '0);
			depth_q  <= elem_cnt_d;
			status_q <= status_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = popped_q;
	assign top_value     = top_q;
	assign max_value     = max_q;
	assign is_empty      = empty_q;
	assign depth_used    = depth_q;
	assign status        = status_q;

	// There can never be more maximum pairs than elements.
	assert property (@(posedge clk) disable iff (!arst_n)
		pair_cnt_q <= elem_cnt_q)
		else $error("pair count exceeds element count");

	assert property (@(posedge clk) disable iff (!arst_n)
		elem_cnt_q <= FULL_COUNT)
		else $error("element count beyond stack depth");

	// A successful push grows the reported depth by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_PUSH && elem_cnt_q != FULL_COUNT
		|=> out_valid && depth_used == $past(elem_cnt_q) + CW'(1))
		else $error("push did not grow the stack");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_value == '0 && max_value == '0)
		else $error("empty stack reports nonzero top or maximum");

	// Elements present implies at least one maximum pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		elem_cnt_q != '0 |-> pair_cnt_q != '0)
		else $error("elements held without a maximum pair");

endmodule
`default_nettype wire

/* rtl/core/mts_cell.sv */
// One storage cell of a shifting stack chain.
`default_nettype none
module mts_cell import mts_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire cell_op_t         op,
	input  wire logic [WIDTH-1:0] from_prev,
	input  wire logic [WIDTH-1:0] from_next,
	output logic      [WIDTH-1:0] data
);

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_HOLD:      data_q <= data_q;
			OP_TAKE_PREV: data_q <= from_prev;
			OP_TAKE_NEXT: data_q <= from_next;
			default:      data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule
`default_nettype wire

/* rtl/core/mts_chain.sv */
// A row of stack cells; cell 0 is the top, a push shifts toward the bottom.
`default_nettype none
module mts_chain import mts_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic             clk,
	input  wire cell_op_t         op_head,
	input  wire cell_op_t         op_body,
	input  wire logic [WIDTH-1:0] head_in,
	output logic      [WIDTH-1:0] head,
	output logic      [WIDTH-1:0] second
);

	logic [WIDTH-1:0] link [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] prev_data;
		logic [WIDTH-1:0] next_data;
		cell_op_t         cell_op;

		if (i == 0) begin : g_head
			assign prev_data = head_in;
			assign cell_op   = op_head;
		end else begin : g_body
			assign prev_data = link[i-1];
			assign cell_op   = op_body;
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_data = '0;
		end else begin : g_inner
			assign next_data = link[i+1];
		end

		mts_cell #(.WIDTH(WIDTH)) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.from_prev (prev_data),
			.from_next (next_data),
			.data      (link[i])
		);
	end

	assign head   = link[0];
	assign second = link[1];

endmodule
`default_nettype wire
